// ===== rtl/pump_dose_time_converter_macros.svh =====
// assertion macros for the pump dose/time converter
// used by pump_dose_time_converter.sv; needs a clock i_clk and reset i_rst_n in scope
`ifndef PUMP_DOSE_TIME_CONVERTER_MACROS_SVH
`define PUMP_DOSE_TIME_CONVERTER_MACROS_SVH

// same-cycle implication, disabled during reset
`define PDT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define PDT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pdt_pkg.sv =====
// shared types and constants of the pump dose/time converter
// no dependencies; used by pump_dose_time_converter
`default_nettype none

package pdt_pkg;

    // pump count and field widths
    localparam int NUM_PUMPS   = 4;
    localparam int PUMP_W      = 4;
    localparam int PUMP_CMP_W  = PUMP_W + 1;
    localparam int PUMP_IDX_W  = (NUM_PUMPS > 1) ? $clog2(NUM_PUMPS) : 1;
    localparam int CMD_W       = 2;
    localparam int VOL_W       = 24;
    localparam int FLOW_W      = 24;
    localparam int DUR_W       = 32;
    localparam int DEAD_W      = 16;
    localparam int CORR_W      = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;

    // arithmetic
    localparam int MUL_A_W     = 40;
    localparam int MUL_B_W     = 24;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
    localparam int PROD_W      = 56;
    localparam int NUM_W       = 70;
    localparam int Q14_SHIFT   = 14;
    localparam int DIV_STEPS   = 32;
    localparam int CNT_W       = $clog2(DIV_STEPS);
    localparam int MS_PER_MIN  = 60000;

    // reset values
    localparam logic [FLOW_W-1:0] FLOW_RESET      = 24'd25600;
    localparam logic [VOL_W-1:0]  MIN_DOSE_RESET  = 24'd256;
    localparam logic [VOL_W-1:0]  MAX_DOSE_RESET  = 24'd128000;
    localparam logic [DEAD_W-1:0] DEAD_TIME_RESET = 16'd100;
    localparam logic [CORR_W-1:0] CORR_RESET      = 16'd16384;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET_FLOW    = 2'd0,
        CMD_TO_DURATION = 2'd1,
        CMD_TO_VOLUME   = 2'd2,
        CMD_QUERY       = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_DOSE   = 2'd0,
        CFG_MAX_DOSE   = 2'd1,
        CFG_DEAD_TIME  = 2'd2,
        CFG_CORRECTION = 2'd3
    } t_cfg_idx;

endpackage

`default_nettype wire

// ===== rtl/pump_dose_time_converter.sv =====
// pump dose/time converter: per-pump flow table and a shared multiply/divide sequencer
// depends on pdt_pkg and pump_dose_time_converter_macros.svh
// to_duration, to_volume on a valid pump: S_MUL1, S_MUL2 (two passes through one 40x24
// multiplier), S_DIV (overflow check, 32 restoring divide steps), S_OUT; others go to S_OUT
// busy is low again in the strobe cycle; one word at a time; no output stall
// synchronous active-low reset: flow table 100.0 mL/min, flags clear, registers to defaults
`default_nettype none

`include "pump_dose_time_converter_macros.svh"

module pump_dose_time_converter (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // command word
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [pdt_pkg::CMD_W-1:0]        i_cmd,
    input  wire logic [pdt_pkg::PUMP_W-1:0]       i_pump,
    input  wire logic [pdt_pkg::FLOW_W-1:0]       i_flow_in,
    input  wire logic [pdt_pkg::VOL_W-1:0]        i_volume_in,
    input  wire logic [pdt_pkg::DUR_W-1:0]        i_duration_in,
    // result word
    output logic                                  o_valid,
    output logic                                  o_ok,
    output logic [pdt_pkg::DUR_W-1:0]             o_duration_out,
    output logic [pdt_pkg::DUR_W-1:0]             o_volume_out,
    output logic [pdt_pkg::FLOW_W-1:0]            o_flow_out,
    output logic                                  o_is_calibrated,
    // configuration write channel
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [pdt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [pdt_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL1 = 5'b00010,
        S_MUL2 = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    // sequencer, plus an overflow check folded into S_DIV via r_chk
    t_state                            r_state, n_state;
    logic                              r_chk;
    logic [pdt_pkg::CNT_W-1:0]         r_cnt;

    // configuration registers
    logic [pdt_pkg::VOL_W-1:0]         r_min_dose;
    logic [pdt_pkg::VOL_W-1:0]         r_max_dose;
    logic [pdt_pkg::DEAD_W-1:0]        r_dead;
    logic [pdt_pkg::CORR_W-1:0]        r_corr;

    // pump state
    logic [pdt_pkg::FLOW_W-1:0]        r_flow_tab [pdt_pkg::NUM_PUMPS];
    logic [pdt_pkg::NUM_PUMPS-1:0]     r_cal_flags;

    // captured item
    pdt_pkg::t_cmd                     r_cmd;
    logic                              r_pump_ok;
    logic [pdt_pkg::PUMP_IDX_W-1:0]    r_idx;
    logic [pdt_pkg::FLOW_W-1:0]        r_flow_in;
    logic [pdt_pkg::FLOW_W-1:0]        r_flow;
    logic                              r_cal;
    logic [pdt_pkg::DUR_W-1:0]         r_opnd;

    // datapath
    logic [pdt_pkg::PROD_W-1:0]        r_prod;
    logic [pdt_pkg::NUM_W-1:0]         r_num;
    logic [pdt_pkg::DUR_W-1:0]         r_dvs;
    logic [pdt_pkg::DUR_W-1:0]         r_rem;
    logic [pdt_pkg::DUR_W-1:0]         r_quo;
    logic                              r_sat;
    logic                              r_zero;

    // result registers
    logic                              r_valid;
    logic                              r_ok;
    logic [pdt_pkg::DUR_W-1:0]         r_dur_out;
    logic [pdt_pkg::DUR_W-1:0]         r_vol_out;
    logic [pdt_pkg::FLOW_W-1:0]        r_flow_out;
    logic                              r_cal_out;

    logic                              accept;
    logic                              cfg_we;
    logic [pdt_pkg::PUMP_IDX_W-1:0]    in_idx;
    logic                              in_pump_ok;
    logic [pdt_pkg::VOL_W-1:0]         v_lo;
    logic [pdt_pkg::VOL_W-1:0]         v_clamp;
    logic [pdt_pkg::DUR_W-1:0]         run;
    logic                              is_dur;
    logic [pdt_pkg::MUL_A_W-1:0]       m_a;
    logic [pdt_pkg::MUL_B_W-1:0]       m_b;
    logic [pdt_pkg::MUL_P_W-1:0]       m_p;
    logic [pdt_pkg::DUR_W:0]           d_t;
    logic [pdt_pkg::DUR_W:0]           d_diff;
    logic                              d_ge;
    logic [pdt_pkg::DUR_W:0]           dsum;
    logic                              set_ok;
    logic [pdt_pkg::DUR_W-1:0]         dur_res;
    logic [pdt_pkg::DUR_W-1:0]         vol_res;

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign is_dur      = (r_cmd == pdt_pkg::CMD_TO_DURATION);

    // input decode, clamp and dead-time subtract ahead of capture
    assign in_idx     = i_pump[pdt_pkg::PUMP_IDX_W-1:0];
    assign in_pump_ok = ({1'b0, i_pump} < pdt_pkg::PUMP_CMP_W'(pdt_pkg::NUM_PUMPS));
    assign v_lo       = (i_volume_in < r_min_dose) ? r_min_dose : i_volume_in;
    assign v_clamp    = (v_lo > r_max_dose) ? r_max_dose : v_lo;
    assign run        = (i_duration_in > {16'b0, r_dead})
                        ? (i_duration_in - {16'b0, r_dead}) : '0;

    // shared multiplier operand select
    always_comb begin
        m_a = '0;
        m_b = '0;
        if (r_state == S_MUL1) begin
            if (is_dur) begin
                m_a = {16'b0, r_opnd[pdt_pkg::VOL_W-1:0]};
                m_b = {8'b0, r_corr};
            end else begin
                m_a = {8'b0, r_opnd};
                m_b = r_flow;
            end
        end else begin
            if (is_dur) begin
                m_a = r_prod[pdt_pkg::MUL_A_W-1:0];
                m_b = pdt_pkg::MUL_B_W'(pdt_pkg::MS_PER_MIN);
            end else begin
                m_a = pdt_pkg::MUL_A_W'(pdt_pkg::MS_PER_MIN);
                m_b = {8'b0, r_corr};
            end
        end
    end

    assign m_p = {24'b0, m_a} * {40'b0, m_b};

    // one restoring divide step
    assign d_t    = {r_rem, r_num[pdt_pkg::DUR_W-1]};
    assign d_ge   = (d_t >= {1'b0, r_dvs});
    assign d_diff = d_t - {1'b0, r_dvs};

    // final result formation
    assign dsum   = {1'b0, r_quo} + {17'b0, r_dead};
    assign set_ok = (r_cmd == pdt_pkg::CMD_SET_FLOW) && (r_flow_in != '0);

    always_comb begin
        if (r_flow == '0) begin
            dur_res = '0;
        end else if (r_sat || dsum[pdt_pkg::DUR_W]) begin
            dur_res = '1;
        end else begin
            dur_res = dsum[pdt_pkg::DUR_W-1:0];
        end
        if (r_zero) begin
            vol_res = '0;
        end else if (r_sat) begin
            vol_res = '1;
        end else begin
            vol_res = r_quo;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (in_pump_ok && (i_cmd == pdt_pkg::CMD_TO_DURATION ||
                                       i_cmd == pdt_pkg::CMD_TO_VOLUME)) begin
                        n_state = S_MUL1;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_DIV;
            S_DIV: begin
                if (!r_chk && r_cnt == pdt_pkg::CNT_W'(pdt_pkg::DIV_STEPS - 1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_chk   <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_OUT);
            if (r_state == S_MUL2) begin
                r_chk <= 1'b1;
                r_cnt <= '0;
            end else if (r_state == S_DIV) begin
                if (r_chk) begin
                    r_chk <= 1'b0;
                end else begin
                    r_cnt <= r_cnt + pdt_pkg::CNT_W'(1);
                end
            end
        end
    end

    // configuration registers and pump state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dose  <= pdt_pkg::MIN_DOSE_RESET;
            r_max_dose  <= pdt_pkg::MAX_DOSE_RESET;
            r_dead      <= pdt_pkg::DEAD_TIME_RESET;
            r_corr      <= pdt_pkg::CORR_RESET;
            r_cal_flags <= '0;
            for (int i = 0; i < pdt_pkg::NUM_PUMPS; i++) begin
                r_flow_tab[i] <= pdt_pkg::FLOW_RESET;
            end
        end else begin
            if (cfg_we) begin
                unique case (pdt_pkg::t_cfg_idx'(i_cfg_index))
                    pdt_pkg::CFG_MIN_DOSE:   r_min_dose <= i_cfg_data;
                    pdt_pkg::CFG_MAX_DOSE:   r_max_dose <= i_cfg_data;
                    pdt_pkg::CFG_DEAD_TIME:  r_dead <= i_cfg_data[pdt_pkg::DEAD_W-1:0];
                    pdt_pkg::CFG_CORRECTION: r_corr <= i_cfg_data[pdt_pkg::CORR_W-1:0];
                    default: ;
                endcase
            end
            if (r_state == S_OUT && r_pump_ok && set_ok) begin
                r_flow_tab[r_idx]  <= r_flow_in;
                r_cal_flags[r_idx] <= 1'b1;
            end
        end
    end

    // item capture and arithmetic datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd     <= pdt_pkg::t_cmd'(i_cmd);
            r_pump_ok <= in_pump_ok;
            r_idx     <= in_idx;
            r_flow_in <= i_flow_in;
            r_flow    <= r_flow_tab[in_idx];
            r_cal     <= r_cal_flags[in_idx];
            r_opnd    <= (i_cmd == pdt_pkg::CMD_TO_DURATION) ? {8'b0, v_clamp} : run;
        end
        unique case (r_state)
            S_MUL1: r_prod <= m_p[pdt_pkg::PROD_W-1:0];
            S_MUL2: begin
                if (is_dur) begin
                    // (v * corr * 60000) >> 14 over the flow rate
                    r_num <= {{(pdt_pkg::NUM_W - pdt_pkg::PROD_W + pdt_pkg::Q14_SHIFT){1'b0}},
                              m_p[pdt_pkg::PROD_W-1:pdt_pkg::Q14_SHIFT]};
                    r_dvs <= {8'b0, r_flow};
                end else begin
                    // (run * flow) << 14 over 60000 * corr
                    r_num <= {r_prod, {pdt_pkg::Q14_SHIFT{1'b0}}};
                    r_dvs <= m_p[pdt_pkg::DUR_W-1:0];
                end
            end
            S_DIV: begin
                if (r_chk) begin
                    // quotient overflows 32 bits when the upper part reaches the divisor
                    r_sat  <= (r_num[pdt_pkg::NUM_W-1:pdt_pkg::DUR_W] >= {6'b0, r_dvs});
                    r_zero <= (r_num == '0);
                    r_rem  <= r_num[2*pdt_pkg::DUR_W-1:pdt_pkg::DUR_W];
                end else begin
                    r_rem <= d_ge ? d_diff[pdt_pkg::DUR_W-1:0] : d_t[pdt_pkg::DUR_W-1:0];
                    r_quo <= {r_quo[pdt_pkg::DUR_W-2:0], d_ge};
                    r_num <= {r_num[pdt_pkg::NUM_W-2:0], 1'b0};
                end
            end
            S_OUT: begin
                r_ok       <= r_pump_ok &&
                              ((r_cmd != pdt_pkg::CMD_SET_FLOW) || (r_flow_in != '0));
                r_dur_out  <= (r_pump_ok && is_dur) ? dur_res : '0;
                r_vol_out  <= (r_pump_ok && r_cmd == pdt_pkg::CMD_TO_VOLUME) ? vol_res : '0;
                r_flow_out <= !r_pump_ok ? '0 : (set_ok ? r_flow_in : r_flow);
                r_cal_out  <= r_pump_ok && (set_ok || r_cal);
            end
            default: ;
        endcase
    end

    assign o_valid         = r_valid;
    assign o_ok            = r_ok;
    assign o_duration_out  = r_dur_out;
    assign o_volume_out    = r_vol_out;
    assign o_flow_out      = r_flow_out;
    assign o_is_calibrated = r_cal_out;

    // checks
    `PDT_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted word did not raise busy")
    `PDT_ASSERT_NEXT(a_out_strobe, r_state == S_OUT, o_valid && !busy,
                     "result word not strobed after output state")
    `PDT_ASSERT_NOW(a_rem_bound, r_state == S_DIV && !r_chk && !r_sat, r_rem < r_dvs,
                    "divide remainder out of range")
    `PDT_ASSERT_NOW(a_reject_zero, o_valid && !o_ok,
                    o_duration_out == '0 && o_volume_out == '0,
                    "rejected word carries a conversion result")

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// testbench of pump_dose_time_converter: predicts each result word and checks it field by field
// runs directed words, register extremes and randomized traffic; depends on pdt_pkg and the rtl
`timescale 1ns / 1ps

module tb;

    localparam int LIMIT_CYCLES = 600000;
    localparam int REPORT_MAX   = 10;
    localparam int RANDOM_WORDS = 1650;
    localparam int PHASES       = 10;

    // one command word and one result word
    typedef struct packed {
        pdt_pkg::t_cmd                cmd;
        logic [pdt_pkg::PUMP_W-1:0]   pump;
        logic [pdt_pkg::FLOW_W-1:0]   flow;
        logic [pdt_pkg::VOL_W-1:0]    volume;
        logic [pdt_pkg::DUR_W-1:0]    duration;
    } t_dose_cmd;

    typedef struct packed {
        logic                         ok;
        logic [pdt_pkg::DUR_W-1:0]    duration;
        logic [pdt_pkg::DUR_W-1:0]    volume;
        logic [pdt_pkg::FLOW_W-1:0]   flow;
        logic                         cal;
    } t_dose_result;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               start;
    logic                               busy;
    logic [pdt_pkg::CMD_W-1:0]          i_cmd;
    logic [pdt_pkg::PUMP_W-1:0]         i_pump;
    logic [pdt_pkg::FLOW_W-1:0]         i_flow_in;
    logic [pdt_pkg::VOL_W-1:0]          i_volume_in;
    logic [pdt_pkg::DUR_W-1:0]          i_duration_in;
    logic                               o_valid;
    logic                               o_ok;
    logic [pdt_pkg::DUR_W-1:0]          o_duration_out;
    logic [pdt_pkg::DUR_W-1:0]          o_volume_out;
    logic [pdt_pkg::FLOW_W-1:0]         o_flow_out;
    logic                               o_is_calibrated;
    logic                               i_cfg_valid;
    logic                               o_cfg_ready;
    logic [pdt_pkg::CFG_IDX_W-1:0]      i_cfg_index;
    logic [pdt_pkg::CFG_DATA_W-1:0]     i_cfg_data;

    // predicted state of the block
    logic [pdt_pkg::FLOW_W-1:0]         rate_tbl [pdt_pkg::NUM_PUMPS];
    logic                               cal_tbl  [pdt_pkg::NUM_PUMPS];
    logic [pdt_pkg::VOL_W-1:0]          reg_min_dose;
    logic [pdt_pkg::VOL_W-1:0]          reg_max_dose;
    logic [pdt_pkg::DEAD_W-1:0]         reg_dead_time;
    logic [pdt_pkg::CORR_W-1:0]         reg_correction;

    t_dose_result           dose_expect_q [$];
    bit                     sender_gaps;
    int                     mismatches;
    int                     results_checked;
    int                     cycle_count;
    int                     cmd_count [4];
    int                     bad_pump_count;
    int                     reg_writes;

    pump_dose_time_converter uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cmd           (i_cmd),
        .i_pump          (i_pump),
        .i_flow_in       (i_flow_in),
        .i_volume_in     (i_volume_in),
        .i_duration_in   (i_duration_in),
        .o_valid         (o_valid),
        .o_ok            (o_ok),
        .o_duration_out  (o_duration_out),
        .o_volume_out    (o_volume_out),
        .o_flow_out      (o_flow_out),
        .o_is_calibrated (o_is_calibrated),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // run time limit
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, dose_expect_q.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // saturate a 64-bit value to 32 bits
    function automatic logic [pdt_pkg::DUR_W-1:0] clip32(input logic [63:0] x);
        return (x > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : x[31:0];
    endfunction

    // volume to pump on time in ms
    function automatic logic [pdt_pkg::DUR_W-1:0] dose_ms(
        input logic [pdt_pkg::VOL_W-1:0] vol_q8,
        input logic [pdt_pkg::FLOW_W-1:0] rate);
        logic [63:0] v;
        logic [63:0] num;
        logic [63:0] den;
        v = 64'(vol_q8);
        if (v < 64'(reg_min_dose)) v = 64'(reg_min_dose);
        if (v > 64'(reg_max_dose)) v = 64'(reg_max_dose);
        if (rate == '0) return '0;
        num = v * 64'(reg_correction) * 64'(pdt_pkg::MS_PER_MIN);
        den = 64'(rate) << pdt_pkg::Q14_SHIFT;
        return clip32(num / den + 64'(reg_dead_time));
    endfunction

    // run time in ms to delivered volume, Q24.8
    function automatic logic [pdt_pkg::DUR_W-1:0] run_volume(
        input logic [pdt_pkg::DUR_W-1:0] ms,
        input logic [pdt_pkg::FLOW_W-1:0] rate);
        logic [63:0] run_ms;
        logic [63:0] prod;
        logic [63:0] div;
        logic [63:0] quo;
        logic [63:0] rem;
        run_ms = (ms > 32'(reg_dead_time)) ? 64'(ms - 32'(reg_dead_time)) : 64'd0;
        if (rate == '0) return '0;
        prod = run_ms * 64'(rate);
        if (prod == 64'd0) return '0;
        if (reg_correction == '0) return 32'hFFFF_FFFF;
        div = 64'(pdt_pkg::MS_PER_MIN) * 64'(reg_correction);
        quo = prod / div;
        rem = prod % div;
        return clip32((quo << pdt_pkg::Q14_SHIFT) + ((rem << pdt_pkg::Q14_SHIFT) / div));
    endfunction

    // expected result of one accepted word; updates the predicted flow table
    function automatic t_dose_result predict_dose(input t_dose_cmd w);
        t_dose_result r;
        r = '0;
        if (w.pump < pdt_pkg::NUM_PUMPS) begin
            r.ok = 1'b1;
            case (w.cmd)
                pdt_pkg::CMD_SET_FLOW: begin
                    if (w.flow != '0) begin
                        rate_tbl[w.pump] = w.flow;
                        cal_tbl[w.pump]  = 1'b1;
                    end else begin
                        r.ok = 1'b0;
                    end
                end
                pdt_pkg::CMD_TO_DURATION:
                    r.duration = dose_ms(w.volume, rate_tbl[w.pump]);
                pdt_pkg::CMD_TO_VOLUME:
                    r.volume   = run_volume(w.duration, rate_tbl[w.pump]);
                default: ;
            endcase
            r.flow = rate_tbl[w.pump];
            r.cal  = cal_tbl[w.pump];
        end
        return r;
    endfunction

    function automatic t_dose_cmd cmd_word(input pdt_pkg::t_cmd cmd, input int pump,
                                           input logic [pdt_pkg::FLOW_W-1:0] flow,
                                           input logic [pdt_pkg::VOL_W-1:0] vol,
                                           input logic [pdt_pkg::DUR_W-1:0] ms);
        t_dose_cmd w;
        w.cmd      = cmd;
        w.pump     = pdt_pkg::PUMP_W'(pump);
        w.flow     = flow;
        w.volume   = vol;
        w.duration = ms;
        return w;
    endfunction

    // result checker: every strobe must match the oldest prediction
    always @(posedge i_clk) begin
        t_dose_result got;
        t_dose_result want;
        if (i_rst_n && o_valid) begin
            got = '{o_ok, o_duration_out, o_volume_out, o_flow_out, o_is_calibrated};
            if (dose_expect_q.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: result word with nothing expected: ok=%0b dur=%h vol=%h",
                             $realtime, o_ok, o_duration_out, o_volume_out);
            end else begin
                want = dose_expect_q.pop_front();
                results_checked = results_checked + 1;
                if (got !== want) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= REPORT_MAX) begin
                        $display("%0t: mismatch on result %0d", $realtime, results_checked);
                        $display("  expected ok=%0b dur=%h vol=%h flow=%h cal=%0b",
                                 want.ok, want.duration, want.volume, want.flow, want.cal);
                        $display("  actual   ok=%0b dur=%h vol=%h flow=%h cal=%0b",
                                 got.ok, got.duration, got.volume, got.flow, got.cal);
                    end
                end
            end
        end
    end

    // send one command word, with an optional idle burst first
    task automatic send_word(input t_dose_cmd w);
        int gap;
        if (sender_gaps && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 18);
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start         <= 1'b1;
        i_cmd         <= w.cmd;
        i_pump        <= w.pump;
        i_flow_in     <= w.flow;
        i_volume_in   <= w.volume;
        i_duration_in <= w.duration;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        dose_expect_q.push_back(predict_dose(w));
        cmd_count[w.cmd] = cmd_count[w.cmd] + 1;
        if (w.pump >= pdt_pkg::NUM_PUMPS) bad_pump_count = bad_pump_count + 1;
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (dose_expect_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input pdt_pkg::t_cfg_idx idx,
                             input logic [pdt_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            pdt_pkg::CFG_MIN_DOSE:   reg_min_dose   = data[pdt_pkg::VOL_W-1:0];
            pdt_pkg::CFG_MAX_DOSE:   reg_max_dose   = data[pdt_pkg::VOL_W-1:0];
            pdt_pkg::CFG_DEAD_TIME:  reg_dead_time  = data[pdt_pkg::DEAD_W-1:0];
            pdt_pkg::CFG_CORRECTION: reg_correction = data[pdt_pkg::CORR_W-1:0];
            default: ;
        endcase
        reg_writes = reg_writes + 1;
    endtask

    // load all four shared registers while the block is idle
    task automatic load_registers(input logic [pdt_pkg::CFG_DATA_W-1:0] min_d,
                                  input logic [pdt_pkg::CFG_DATA_W-1:0] max_d,
                                  input logic [pdt_pkg::CFG_DATA_W-1:0] dead,
                                  input logic [pdt_pkg::CFG_DATA_W-1:0] corr);
        drain_results();
        write_reg(pdt_pkg::CFG_MIN_DOSE, min_d);
        write_reg(pdt_pkg::CFG_MAX_DOSE, max_d);
        write_reg(pdt_pkg::CFG_DEAD_TIME, dead);
        write_reg(pdt_pkg::CFG_CORRECTION, corr);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // reset contents of the flow table and invalid pump handling
    task automatic test_reset_state();
        for (int p = 0; p < pdt_pkg::NUM_PUMPS; p++)
            send_word(cmd_word(pdt_pkg::CMD_QUERY, p, '0, '0, '0));
        send_word(cmd_word(pdt_pkg::CMD_QUERY, pdt_pkg::NUM_PUMPS, 24'hFFFFFF, 24'hFFFFFF,
                           32'hFFFF_FFFF));
        send_word(cmd_word(pdt_pkg::CMD_TO_DURATION, 15, 24'd1000, 24'd5000, 32'd1000));
    endtask

    // set_flow accept and reject
    task automatic test_flow_table();
        send_word(cmd_word(pdt_pkg::CMD_SET_FLOW, 0, 24'd0, 24'd1, 32'd1));
        send_word(cmd_word(pdt_pkg::CMD_SET_FLOW, 1, 24'hFFFFFF, '0, '0));
        send_word(cmd_word(pdt_pkg::CMD_SET_FLOW, 2, 24'd1, '0, '0));
        send_word(cmd_word(pdt_pkg::CMD_SET_FLOW, 7, 24'd5, '0, '0));
    endtask

    // clamps, dead time boundary and saturation at default registers
    task automatic test_conversion_edges();
        send_word(cmd_word(pdt_pkg::CMD_TO_DURATION, 2, '0, 24'd0, '0));
        send_word(cmd_word(pdt_pkg::CMD_TO_DURATION, 2, '0, 24'hFFFFFF, '0));
        send_word(cmd_word(pdt_pkg::CMD_TO_DURATION, 1, '0, 24'd12345, '0));
        send_word(cmd_word(pdt_pkg::CMD_TO_VOLUME, 1, '0, '0, 32'hFFFF_FFFF));
        send_word(cmd_word(pdt_pkg::CMD_TO_VOLUME, 0, '0, '0, 32'd100));
        send_word(cmd_word(pdt_pkg::CMD_TO_VOLUME, 0, '0, '0, 32'd0));
        send_word(cmd_word(pdt_pkg::CMD_TO_VOLUME, 2, '0, '0, 32'd160000));
    endtask

    // min above max, zero correction, then the widest register settings
    task automatic test_register_extremes();
        load_registers(24'h010000, 24'h000100, 24'h00FFFF, 24'h000000);
        send_word(cmd_word(pdt_pkg::CMD_TO_DURATION, 1, '0, 24'd5, '0));
        send_word(cmd_word(pdt_pkg::CMD_TO_VOLUME, 1, '0, '0, 32'hFFFF_FFFF));
        send_word(cmd_word(pdt_pkg::CMD_TO_VOLUME, 0, '0, '0, 32'h0001_0000));
        send_word(cmd_word(pdt_pkg::CMD_TO_VOLUME, 0, '0, '0, 32'd5));
        load_registers(24'h000000, 24'hFFFFFF, 24'h000000, 24'h00FFFF);
        send_word(cmd_word(pdt_pkg::CMD_TO_DURATION, 2, '0, 24'hFFFFFF, '0));
        send_word(cmd_word(pdt_pkg::CMD_TO_DURATION, 1, '0, 24'd0, '0));
        send_word(cmd_word(pdt_pkg::CMD_TO_VOLUME, 1, '0, '0, 32'hFFFF_FFFF));
    endtask

    function automatic logic [pdt_pkg::CFG_DATA_W-1:0] pick_correction();
        logic [pdt_pkg::CORR_W-1:0] c;
        case ($urandom_range(0, 9))
            0:       c = '0;
            1:       c = 16'd1;
            2:       c = 16'hFFFF;
            3:       c = pdt_pkg::CORR_RESET;
            4:       c = 16'($urandom);
            default: c = 16'($urandom_range(8192, 32768));
        endcase
        // upper bits of a 16-bit register write are dont-care
        return {($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00, c};
    endfunction

    function automatic t_dose_cmd random_word();
        t_dose_cmd w;
        int sel;
        sel = $urandom_range(0, 9);
        w.cmd  = (sel < 2) ? pdt_pkg::CMD_SET_FLOW : (sel < 5) ? pdt_pkg::CMD_TO_DURATION :
                 (sel < 8) ? pdt_pkg::CMD_TO_VOLUME : pdt_pkg::CMD_QUERY;
        w.pump = ($urandom_range(0, 7) == 0) ? pdt_pkg::PUMP_W'($urandom) :
                 pdt_pkg::PUMP_W'($urandom_range(0, pdt_pkg::NUM_PUMPS - 1));
        case ($urandom_range(0, 9))
            0:       w.flow = '0;
            1:       w.flow = 24'd1;
            2:       w.flow = 24'hFFFFFF;
            3, 4, 5: w.flow = 24'($urandom_range(256, 256000));
            default: w.flow = 24'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0:       w.volume = '0;
            1:       w.volume = 24'hFFFFFF;
            2:       w.volume = reg_min_dose ^ 24'($urandom_range(0, 3));
            3:       w.volume = reg_max_dose ^ 24'($urandom_range(0, 3));
            4, 5, 6: w.volume = 24'($urandom_range(0, 200000));
            default: w.volume = 24'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0:       w.duration = '0;
            1:       w.duration = 32'hFFFF_FFFF;
            2:       w.duration = 32'(reg_dead_time) + 32'($urandom_range(0, 2)) - 32'd1;
            3, 4, 5: w.duration = 32'($urandom_range(0, 600000));
            default: w.duration = $urandom;
        endcase
        return w;
    endfunction

    // random register settings per phase, random words within each phase
    task automatic test_random_traffic();
        logic [pdt_pkg::CFG_DATA_W-1:0] min_d;
        logic [pdt_pkg::CFG_DATA_W-1:0] max_d;
        logic [pdt_pkg::CFG_DATA_W-1:0] dead;
        for (int ph = 0; ph < PHASES; ph++) begin
            min_d = ($urandom_range(0, 4) == 0) ? 24'($urandom) : 24'($urandom_range(0, 2560));
            case ($urandom_range(0, 5))
                0:       max_d = 24'hFFFFFF;
                1:       max_d = 24'($urandom);
                default: max_d = min_d + 24'($urandom_range(0, 256000));
            endcase
            dead = ($urandom_range(0, 2) == 0) ? 24'($urandom) : 24'($urandom_range(0, 500));
            load_registers(min_d, max_d, dead, pick_correction());
            // no idling in the last phase, and none in some earlier ones
            sender_gaps = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
            repeat (RANDOM_WORDS / PHASES) send_word(random_word());
        end
    endtask

    initial begin
        mismatches      = 0;
        results_checked = 0;
        bad_pump_count  = 0;
        reg_writes      = 0;
        for (int c = 0; c < 4; c++) cmd_count[c] = 0;
        for (int p = 0; p < pdt_pkg::NUM_PUMPS; p++) begin
            rate_tbl[p] = pdt_pkg::FLOW_RESET;
            cal_tbl[p]  = 1'b0;
        end
        reg_min_dose   = pdt_pkg::MIN_DOSE_RESET;
        reg_max_dose   = pdt_pkg::MAX_DOSE_RESET;
        reg_dead_time  = pdt_pkg::DEAD_TIME_RESET;
        reg_correction = pdt_pkg::CORR_RESET;
        sender_gaps    = 1'b1;

        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_cmd         = '0;
        i_pump        = '0;
        i_flow_in     = '0;
        i_volume_in   = '0;
        i_duration_in = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_flow_table();
        test_conversion_edges();
        test_register_extremes();
        test_random_traffic();

        // let any stray strobe show up after the last result
        drain_results();
        repeat (40) @(posedge i_clk);

        $display("covered %0d set_flow, %0d to_duration, %0d to_volume, %0d query words",
                 cmd_count[pdt_pkg::CMD_SET_FLOW], cmd_count[pdt_pkg::CMD_TO_DURATION],
                 cmd_count[pdt_pkg::CMD_TO_VOLUME], cmd_count[pdt_pkg::CMD_QUERY]);
        $display("%0d bad pump words, %0d register writes, %0d results checked, %0d mismatches",
                 bad_pump_count, reg_writes, results_checked, mismatches);
        if (mismatches == 0 && dose_expect_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/pdt_pkg.sv
rtl/pump_dose_time_converter.sv
tb/tb.sv
